[hw/rtl/mwbps_pkg.sv]
// Shared package for the masked wildcard byte pattern search core.
// Holds field widths, reset values, request and register codes, and the
// pattern entry and queue entry types. Depends on nothing.
package mwbps_pkg;

   localparam int PATTERN_MAX_DEFAULT = 64;
   localparam int CMP_W = 10;
   localparam int QUEUE_DEPTH = 4;

   localparam int BYTE_W = 8;
   localparam int TYPE_W = 2;
   localparam int ENTRY_INDEX_W = 6;
   localparam int WORD_W = 32;
   localparam int LENGTH_REG_W = 7;
   localparam int CSR_INDEX_W = 2;

   localparam logic [LENGTH_REG_W-1:0] LENGTH_RESET = 7'd1;
   localparam logic [BYTE_W-1:0] MASK_RESET = 8'hfc;
   localparam logic [WORD_W-1:0] BASE_RESET = 32'h8001_0000;
   localparam logic [WORD_W-1:0] CALL_MASK = 32'h0fff_ffff;
   localparam logic [WORD_W-1:0] CALL_OP = 32'h0c00_0000;

   typedef enum logic [TYPE_W-1:0] {
      REQ_LOAD = 2'd0,
      REQ_SCAN = 2'd1,
      REQ_RESTART = 2'd2
   } req_kind_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PATTERN_LENGTH = 2'd0,
      CSR_COMPARE_MASK = 2'd1,
      CSR_BASE_ADDRESS = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic care;
      logic [BYTE_W-1:0] value;
   } pat_entry_type;

   typedef struct packed {
      logic restart;
      logic window_hit;
      logic [WORD_W-1:0] start;
   } queue_entry_type;

endpackage

[hw/rtl/mwbps_if.sv]
// Channel interfaces of the pattern search core: request, response and
// register write channels, each with valid, ready and payload.
// Depends on mwbps_pkg for the field widths.
interface mwbps_req_if import mwbps_pkg::*; ();
   logic valid;
   logic ready;
   logic [TYPE_W-1:0] req_type;
   logic [ENTRY_INDEX_W-1:0] entry_index;
   logic entry_care;
   logic [BYTE_W-1:0] entry_value;
   logic [BYTE_W-1:0] data_byte;

   modport source(output valid, req_type, entry_index, entry_care, entry_value, data_byte,
                  input ready);
   modport sink(input valid, req_type, entry_index, entry_care, entry_value, data_byte,
                output ready);
endinterface

interface mwbps_rsp_if import mwbps_pkg::*; ();
   logic valid;
   logic ready;
   logic [WORD_W-1:0] match_number;
   logic [WORD_W-1:0] match_offset;
   logic [WORD_W-1:0] call_word;

   modport source(output valid, match_number, match_offset, call_word, input ready);
   modport sink(input valid, match_number, match_offset, call_word, output ready);
endinterface

interface mwbps_csr_if import mwbps_pkg::*; ();
   logic valid;
   logic ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [WORD_W-1:0] data;

   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

[hw/rtl/mwbps_ram.sv]
// Generic single write port, single read port RAM with registered read data.
// Depends on nothing.
module mwbps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input logic clock,
   input logic wr_en,
   input logic [ADDR_W-1:0] wr_addr,
   input logic [WIDTH-1:0] wr_data,
   input logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/mwbps_front.sv]
// Front end: accepts request beats, stores pattern entries, keeps the byte
// window and an aligned copy of the pattern, and compares the window.
// Depends on mwbps_pkg, mwbps_if and mwbps_ram.
module mwbps_front import mwbps_pkg::*; #(
   parameter int PATTERN_MAX = PATTERN_MAX_DEFAULT,
   localparam int LEN_W = $clog2(PATTERN_MAX + 1)
) (
   input logic clock,
   input logic reset,
   mwbps_req_if.sink req,
   input logic [LEN_W-1:0] eff_len,
   input logic [BYTE_W-1:0] compare_mask,
   input logic realign_start,
   output logic push_valid,
   output queue_entry_type push_data,
   input logic queue_full
);

   localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

   logic accept;
   logic is_load;
   logic is_scan;
   logic is_restart;
   logic [CMP_W-1:0] len_cw;
   logic [CMP_W-1:0] idx_cw;
   logic load_in_range;
   pat_entry_type load_entry;
   pat_entry_type rd_entry;

   logic sweep_active_ff, sweep_active_in;
   logic sweep_pend_ff, sweep_pend_in;
   logic [IDX_W-1:0] sweep_idx_ff, sweep_idx_in;
   logic [IDX_W-1:0] sweep_pidx_ff, sweep_pidx_in;

   logic aw_en;
   logic [CMP_W-1:0] aw_pos;
   pat_entry_type aw_data;
   pat_entry_type aligned_ff [PATTERN_MAX];
   pat_entry_type aligned_in [PATTERN_MAX];

   logic [BYTE_W-1:0] window_ff [PATTERN_MAX];
   logic [BYTE_W-1:0] window_in [PATTERN_MAX];
   logic [PATTERN_MAX-1:0] cell_ok;

   logic [WORD_W-1:0] offset_ff, offset_in;

   assign req.ready = !(sweep_active_ff || sweep_pend_ff) && !queue_full;
   assign accept = req.valid && req.ready;
   assign is_load = accept && (req.req_type == REQ_LOAD);
   assign is_scan = accept && (req.req_type == REQ_SCAN);
   assign is_restart = accept && (req.req_type == REQ_RESTART);

   assign len_cw = CMP_W'(eff_len);
   assign idx_cw = CMP_W'(req.entry_index);
   assign load_in_range = idx_cw < CMP_W'(PATTERN_MAX);
   assign load_entry = '{care: req.entry_care, value: req.entry_value};

   mwbps_ram #(
      .WIDTH($bits(pat_entry_type)),
      .DEPTH(PATTERN_MAX)
   ) u_pattern_ram (
      .clock(clock),
      .wr_en(is_load && load_in_range),
      .wr_addr(idx_cw[IDX_W-1:0]),
      .wr_data(load_entry),
      .rd_addr(sweep_idx_ff),
      .rd_data(rd_entry)
   );

   // After a length change the aligned copy is rebuilt from the pattern RAM,
   // one entry per cycle, with entry i landing at position length-1-i.
   always_comb begin
      sweep_active_in = sweep_active_ff;
      sweep_idx_in = sweep_idx_ff;
      sweep_pend_in = sweep_active_ff;
      sweep_pidx_in = sweep_idx_ff;
      if (sweep_active_ff) begin
         sweep_idx_in = sweep_idx_ff + IDX_W'(1);
         if (CMP_W'(sweep_idx_ff) == len_cw - CMP_W'(1)) begin
            sweep_active_in = 1'b0;
         end
      end
      if (realign_start) begin
         sweep_active_in = 1'b1;
         sweep_idx_in = '0;
      end
   end

   always_comb begin
      aw_en = 1'b0;
      aw_pos = '0;
      aw_data = load_entry;
      if (sweep_pend_ff) begin
         aw_en = 1'b1;
         aw_pos = len_cw - CMP_W'(1) - CMP_W'(sweep_pidx_ff);
         aw_data = rd_entry;
      end else if (is_load && (idx_cw < len_cw)) begin
         aw_en = 1'b1;
         aw_pos = len_cw - CMP_W'(1) - idx_cw;
      end
   end

   always_comb begin
      for (int j = 0; j < PATTERN_MAX; j++) begin
         aligned_in[j] = (aw_en && (aw_pos == CMP_W'(j))) ? aw_data : aligned_ff[j];
      end
   end

   assign window_in[0] = req.data_byte;

   for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
      if (j > 0) begin : g_shift
         assign window_in[j] = window_ff[j-1];
      end
      assign cell_ok[j] = !(aligned_ff[j].care && (CMP_W'(j) < len_cw)) ||
                          (((window_in[j] ^ aligned_ff[j].value) & compare_mask) == '0);
   end

   always_comb begin
      offset_in = offset_ff;
      if (is_restart) begin
         offset_in = '0;
      end else if (is_scan) begin
         offset_in = offset_ff + WORD_W'(1);
      end
   end

   assign push_valid = is_scan || is_restart;
   assign push_data.restart = is_restart;
   assign push_data.window_hit = &cell_ok;
   assign push_data.start = offset_ff + WORD_W'(1) - WORD_W'(eff_len);

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_active_ff <= 1'b0;
         sweep_pend_ff <= 1'b0;
         offset_ff <= '0;
      end else begin
         sweep_active_ff <= sweep_active_in;
         sweep_pend_ff <= sweep_pend_in;
         offset_ff <= offset_in;
      end
   end

   always_ff @(posedge clock) begin
      sweep_idx_ff <= sweep_idx_in;
      sweep_pidx_ff <= sweep_pidx_in;
      aligned_ff <= aligned_in;
      if (is_scan) begin
         window_ff <= window_in;
      end
   end

endmodule

[hw/rtl/mwbps_queue.sv]
// Short queue between the front end and the back end of the search core.
// Depends on mwbps_pkg for the entry type and depth.
module mwbps_queue import mwbps_pkg::*; (
   input logic clock,
   input logic reset,
   input logic push_valid,
   input queue_entry_type push_data,
   output logic full,
   input logic pop_ready,
   output logic pop_valid,
   output queue_entry_type pop_data
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   queue_entry_type entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic do_pop;

   assign full = count_ff == CNT_W'(QUEUE_DEPTH);
   assign pop_valid = count_ff != '0;
   assign pop_data = entries_ff[rd_ptr_ff];
   assign do_pop = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push_valid ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in = count_ff;
      if (push_valid && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (!push_valid && do_pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[hw/rtl/mwbps_back.sv]
// Back end: counts bytes since the last hit or restart, numbers the hits and
// forms the call word in the response register.
// Depends on mwbps_pkg and mwbps_if.
module mwbps_back import mwbps_pkg::*; #(
   parameter int PATTERN_MAX = PATTERN_MAX_DEFAULT,
   localparam int LEN_W = $clog2(PATTERN_MAX + 1)
) (
   input logic clock,
   input logic reset,
   input logic pop_valid,
   input queue_entry_type pop_data,
   output logic pop_ready,
   input logic [LEN_W-1:0] eff_len,
   input logic [WORD_W-1:0] base_address,
   mwbps_rsp_if.source rsp
);

   logic take;
   logic do_pop;
   logic hit;
   logic [LEN_W-1:0] fill_step;
   logic [WORD_W-1:0] call_sum;

   logic [LEN_W-1:0] fill_ff, fill_in;
   logic [WORD_W-1:0] hit_count_ff, hit_count_in;
   logic out_valid_ff, out_valid_in;
   logic [WORD_W-1:0] number_ff, number_in;
   logic [WORD_W-1:0] offset_ff, offset_in;
   logic [WORD_W-1:0] call_ff, call_in;

   assign take = !out_valid_ff || rsp.ready;
   assign pop_ready = take;
   assign do_pop = pop_valid && take;

   assign fill_step = (fill_ff == LEN_W'(PATTERN_MAX)) ? fill_ff : fill_ff + LEN_W'(1);
   assign hit = pop_data.window_hit && (fill_step >= eff_len);
   assign call_sum = pop_data.start + base_address;

   always_comb begin
      fill_in = fill_ff;
      hit_count_in = hit_count_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      number_in = number_ff;
      offset_in = offset_ff;
      call_in = call_ff;
      if (do_pop) begin
         if (pop_data.restart) begin
            fill_in = '0;
            hit_count_in = '0;
         end else if (hit) begin
            fill_in = '0;
            hit_count_in = hit_count_ff + WORD_W'(1);
            out_valid_in = 1'b1;
            number_in = hit_count_ff;
            offset_in = pop_data.start;
            call_in = ((call_sum & CALL_MASK) >> 2) | CALL_OP;
         end else begin
            fill_in = fill_step;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         hit_count_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         fill_ff <= fill_in;
         hit_count_ff <= hit_count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      number_ff <= number_in;
      offset_ff <= offset_in;
      call_ff <= call_in;
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.match_number = number_ff;
   assign rsp.match_offset = offset_ff;
   assign rsp.call_word = call_ff;

endmodule

[hw/rtl/masked_wildcard_byte_pattern_search_core.sv]
// Masked wildcard byte pattern search core, top level.
// Takes one request beat per cycle unless a realign sweep or a full queue
// stalls it; a hit passes through the queue and then the response register
// before it reaches the response port.
// A pattern_length write stalls requests while the aligned pattern is
// rebuilt from the pattern RAM, one entry per cycle.
// Reset clears counters and restores register defaults; pattern entries are
// undefined until loaded. Depends on mwbps_pkg, mwbps_if, front, queue, back.
module masked_wildcard_byte_pattern_search_core import mwbps_pkg::*; #(
   parameter int PATTERN_MAX = PATTERN_MAX_DEFAULT
) (
   input logic clock,
   input logic reset,
   mwbps_req_if.sink req_bus,
   mwbps_rsp_if.source rsp_bus,
   mwbps_csr_if.sink csr_bus
);

   localparam int LEN_W = $clog2(PATTERN_MAX + 1);

   logic csr_write;
   logic realign_start;
   logic [CMP_W-1:0] len_cw;
   logic [CMP_W-1:0] len_clamped;
   logic [LEN_W-1:0] eff_len;

   logic [LENGTH_REG_W-1:0] length_ff, length_in;
   logic [BYTE_W-1:0] mask_ff, mask_in;
   logic [WORD_W-1:0] base_ff, base_in;

   logic push_valid;
   queue_entry_type push_data;
   logic queue_full;
   logic pop_valid;
   logic pop_ready;
   queue_entry_type pop_data;

   assign csr_bus.ready = 1'b1;
   assign csr_write = csr_bus.valid && csr_bus.ready;
   assign realign_start = csr_write && (csr_bus.index == CSR_PATTERN_LENGTH);

   always_comb begin
      length_in = length_ff;
      mask_in = mask_ff;
      base_in = base_ff;
      if (csr_write) begin
         case (csr_index_type'(csr_bus.index))
            CSR_PATTERN_LENGTH: length_in = csr_bus.data[LENGTH_REG_W-1:0];
            CSR_COMPARE_MASK: mask_in = csr_bus.data[BYTE_W-1:0];
            CSR_BASE_ADDRESS: base_in = csr_bus.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= LENGTH_RESET;
         mask_ff <= MASK_RESET;
         base_ff <= BASE_RESET;
      end else begin
         length_ff <= length_in;
         mask_ff <= mask_in;
         base_ff <= base_in;
      end
   end

   assign len_cw = CMP_W'(length_ff);

   always_comb begin
      len_clamped = len_cw;
      if (len_cw == '0) begin
         len_clamped = CMP_W'(1);
      end else if (len_cw > CMP_W'(PATTERN_MAX)) begin
         len_clamped = CMP_W'(PATTERN_MAX);
      end
   end

   assign eff_len = len_clamped[LEN_W-1:0];

   mwbps_front #(
      .PATTERN_MAX(PATTERN_MAX)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req(req_bus),
      .eff_len(eff_len),
      .compare_mask(mask_ff),
      .realign_start(realign_start),
      .push_valid(push_valid),
      .push_data(push_data),
      .queue_full(queue_full)
   );

   mwbps_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push_valid(push_valid),
      .push_data(push_data),
      .full(queue_full),
      .pop_ready(pop_ready),
      .pop_valid(pop_valid),
      .pop_data(pop_data)
   );

   mwbps_back #(
      .PATTERN_MAX(PATTERN_MAX)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .pop_valid(pop_valid),
      .pop_data(pop_data),
      .pop_ready(pop_ready),
      .eff_len(eff_len),
      .base_address(base_ff),
      .rsp(rsp_bus)
   );

endmodule
